// File: hdl/rfp_pkg.sv
// Package with the constants, status codes and helper functions of the RFID frame parser.
`default_nettype none

package rfp_pkg;

    // Frame framing bytes and sizes.
    localparam logic [7:0]  FRAME_START   = 8'h02;
    localparam logic [7:0]  FRAME_END     = 8'h03;
    localparam int          FRAME_LEN     = 14;
    localparam int          TAG_LEN       = 8;
    localparam int          PAYLOAD_LEN   = 12;
    localparam logic [3:0]  LAST_POS      = 4'(FRAME_LEN - 1);
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    // Command codes of an input request.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Status codes of a result.
    localparam logic [2:0] STATUS_NONE     = 3'd0;
    localparam logic [2:0] STATUS_NEW_TAG  = 3'd1;
    localparam logic [2:0] STATUS_REPEAT   = 3'd2;
    localparam logic [2:0] STATUS_CHECKSUM = 3'd3;
    localparam logic [2:0] STATUS_BAD_END  = 3'd4;

    typedef logic [7:0]  char_t;
    typedef logic [63:0] tag_t;

    // Decode one ASCII hex digit; anything other than 0-9 or A-F reads as zero.
    function automatic logic [3:0] hex_value(input char_t ch);
        logic [3:0] val;
        val = 4'd0;
        if (ch >= "0" && ch <= "9")
        begin
            val = 4'(ch - "0");
        end
        else if (ch >= "A" && ch <= "F")
        begin
            val = 4'(ch - "A" + 8'd10);
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// File: hdl/rfp_in_if.sv
// Request channel carrying a received byte or a millisecond tick.
`default_nettype none

interface rfp_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/rfp_out_if.sv
// Result channel carrying the parse status and the reported tag.
`default_nettype none

interface rfp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] tag_chars;

    modport source (output valid, output status, output tag_chars, input ready);
    modport sink   (input valid, input status, input tag_chars, output ready);
endinterface

`default_nettype wire

// File: hdl/rfid_ascii_frame_parser.sv
// The result of an accepted request is registered and shown in the next cycle.
// Throughput: one request per cycle while result.ready does not stall it; the
// result register is refilled in the same cycle that its current result is taken.
// Reset: rst_n clears the frame position, tick count, remembered tag and the
// result valid flag, and loads the forget timeout with 1000.
`default_nettype none

module rfid_ascii_frame_parser
    import rfp_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [15:0] cfg_wdata,
    rfp_in_if.sink      item,
    rfp_out_if.source   result
);

    logic [15:0] forget_timeout_reg;
    logic [3:0]  byte_position_reg, byte_position_next;
    char_t       payload_reg [PAYLOAD_LEN];
    tag_t        remembered_tag_reg, remembered_tag_next;
    logic        remembered_valid_reg, remembered_valid_next;
    logic [15:0] ticks_reg, ticks_next;
    logic        out_valid_reg;
    logic [2:0]  status_reg, status_next;
    tag_t        tag_reg, tag_next;

    logic        accept;
    logic        frame_byte;
    logic [7:0]  checksum;
    tag_t        frame_tag;

    // A request is taken whenever the result register is empty or being emptied.
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    // A byte belongs to a frame once a start byte has opened it.
    assign frame_byte = (item.cmd == CMD_BYTE)
                        && !(byte_position_reg == 4'd0 && item.rx_byte != FRAME_START);

    // Checksum over the six hex pairs and tag assembly from the payload shift line.
    // Payload character k (1 to 12) sits at payload_reg[12 - k].
    always_comb
    begin
        checksum = 8'd0;
        for (int p = 0; p < PAYLOAD_LEN / 2; p++)
        begin
            checksum = checksum ^ {hex_value(payload_reg[PAYLOAD_LEN - 1 - 2 * p]),
                                   hex_value(payload_reg[PAYLOAD_LEN - 2 - 2 * p])};
        end
        frame_tag = '0;
        for (int i = 0; i < TAG_LEN; i++)
        begin
            frame_tag[8 * (TAG_LEN - 1 - i) +: 8] = payload_reg[PAYLOAD_LEN - 3 - i];
        end
    end

    // Next state and result for the request at the input.
    always_comb
    begin
        byte_position_next    = byte_position_reg;
        remembered_tag_next   = remembered_tag_reg;
        remembered_valid_next = remembered_valid_reg;
        ticks_next            = ticks_reg;
        status_next           = STATUS_NONE;
        tag_next              = '0;
        if (item.cmd == CMD_TICK)
        begin
            if (ticks_reg != TICK_MAX)
            begin
                ticks_next = ticks_reg + 16'd1;
            end
            if (remembered_valid_reg && ticks_next > forget_timeout_reg)
            begin
                remembered_valid_next = 1'b0;
            end
        end
        else if (frame_byte)
        begin
            if (byte_position_reg == LAST_POS)
            begin
                byte_position_next = 4'd0;
                if (item.rx_byte != FRAME_END)
                begin
                    status_next = STATUS_BAD_END;
                end
                else
                begin
                    ticks_next = '0;
                    if (checksum != 8'd0)
                    begin
                        status_next = STATUS_CHECKSUM;
                    end
                    else if (remembered_valid_reg && frame_tag == remembered_tag_reg)
                    begin
                        status_next = STATUS_REPEAT;
                    end
                    else
                    begin
                        remembered_tag_next   = frame_tag;
                        remembered_valid_next = 1'b1;
                        status_next           = STATUS_NEW_TAG;
                        tag_next              = frame_tag;
                    end
                end
            end
            else
            begin
                byte_position_next = byte_position_reg + 4'd1;
            end
        end
    end

    // Control state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forget_timeout_reg   <= TIMEOUT_RESET;
            byte_position_reg    <= 4'd0;
            remembered_tag_reg   <= '0;
            remembered_valid_reg <= 1'b0;
            ticks_reg            <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                forget_timeout_reg <= cfg_wdata;
            end
            if (accept)
            begin
                byte_position_reg    <= byte_position_next;
                remembered_tag_reg   <= remembered_tag_next;
                remembered_valid_reg <= remembered_valid_next;
                ticks_reg            <= ticks_next;
                out_valid_reg        <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload shift line and result register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            tag_reg    <= tag_next;
            if (frame_byte)
            begin
                payload_reg[0] <= item.rx_byte;
                for (int i = 1; i < PAYLOAD_LEN; i++)
                begin
                    payload_reg[i] <= payload_reg[i - 1];
                end
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.status    = status_reg;
    assign result.tag_chars = tag_reg;

    // A new tag on the output is the tag now remembered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_NEW_TAG)
        |-> (remembered_valid_reg && tag_reg == remembered_tag_reg))
        else $error("reported new tag does not match remembered tag");

    // Tag characters are only carried with a new tag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != STATUS_NEW_TAG) |-> (tag_reg == '0))
        else $error("tag characters set without a new tag");

    // The frame position never runs past the end byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_position_reg <= LAST_POS)
        else $error("frame position out of range");

    // A completed frame always returns the position to the start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == CMD_BYTE && byte_position_reg == LAST_POS)
        |=> (byte_position_reg == 4'd0))
        else $error("frame position not cleared after end byte");

endmodule

`default_nettype wire
